FILE: rtl/spsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the soft power switch controller.
// No dependencies.
package spsf_pkg;

	localparam int unsigned TICK_W = 16;

	typedef enum logic [2:0] {
		MODE_STARTUP   = 3'd0,
		MODE_IDLE      = 3'd1,
		MODE_WAITSLEEP = 3'd2,
		MODE_SLEEP     = 3'd3,
		MODE_WAITON    = 3'd4,
		MODE_ON        = 3'd5,
		MODE_WAITOFF   = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_SHORT   = 2'd1,
		EV_LONG    = 2'd2,
		EV_RELEASE = 2'd3
	} button_ev_t;

	typedef enum logic [2:0] {
		TONE_NONE     = 3'd0,
		TONE_STOP     = 3'd1,
		TONE_SLEEP    = 3'd2,
		TONE_WAITON   = 3'd3,
		TONE_WAITOFF  = 3'd4
	} tone_cmd_t;

	localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RST = 16'd5000;

	typedef struct packed {
		logic [1:0] button_event;
		logic       tone_busy;
	} in_item_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       led_on;
		logic       load_on;
		logic [2:0] tone_command;
		logic       mode_changed;
	} out_item_t;

endpackage

FILE: rtl/spsf_fsm.sv
`timescale 1ns / 1ps
// Mode state machine, tick counter and LED/load levels; one step per tick beat.
// Depends on spsf_pkg.
module spsf_fsm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  spsf_pkg::in_item_t          item,
	input  logic [spsf_pkg::TICK_W-1:0] timeout,
	output spsf_pkg::out_item_t         result
);

	spsf_pkg::mode_t             mode_q, mode_d;
	logic [spsf_pkg::TICK_W-1:0] ticks_q, ticks_inc;
	logic                        led_q, load_q, led_d, load_d;
	logic                        changed;
	spsf_pkg::tone_cmd_t         tone;
	spsf_pkg::button_ev_t        ev;

	assign ev        = spsf_pkg::button_ev_t'(item.button_event);
	// Saturate the counter at its top value.
	assign ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;

	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			spsf_pkg::MODE_IDLE: begin
				if (ticks_inc > timeout)
					mode_d = spsf_pkg::MODE_WAITSLEEP;
				else if (ev == spsf_pkg::EV_SHORT)
					mode_d = spsf_pkg::MODE_WAITON;
			end
			spsf_pkg::MODE_WAITSLEEP: begin
				if (!item.tone_busy) mode_d = spsf_pkg::MODE_SLEEP;
			end
			spsf_pkg::MODE_SLEEP: begin
				if (ev == spsf_pkg::EV_SHORT) mode_d = spsf_pkg::MODE_WAITON;
			end
			spsf_pkg::MODE_WAITON: begin
				if (ev == spsf_pkg::EV_LONG)
					mode_d = spsf_pkg::MODE_ON;
				else if (ev == spsf_pkg::EV_RELEASE)
					mode_d = spsf_pkg::MODE_IDLE;
			end
			spsf_pkg::MODE_ON: begin
				if (ev == spsf_pkg::EV_SHORT) mode_d = spsf_pkg::MODE_WAITOFF;
			end
			spsf_pkg::MODE_WAITOFF: begin
				if (ev == spsf_pkg::EV_LONG)
					mode_d = spsf_pkg::MODE_IDLE;
				else if (ev == spsf_pkg::EV_RELEASE)
					mode_d = spsf_pkg::MODE_ON;
			end
			default: begin
				// startup, and the unused code behaves the same
				if (!item.tone_busy) mode_d = spsf_pkg::MODE_IDLE;
			end
		endcase
	end

	assign changed = (mode_d != mode_q);

	// Entry actions on a state change
	always_comb begin
		tone   = spsf_pkg::TONE_NONE;
		led_d  = led_q;
		load_d = load_q;
		if (changed) begin
			unique case (mode_d)
				spsf_pkg::MODE_IDLE: begin
					tone = spsf_pkg::TONE_STOP; led_d = 1'b1; load_d = 1'b0;
				end
				spsf_pkg::MODE_WAITSLEEP: begin
					tone = spsf_pkg::TONE_SLEEP; led_d = 1'b0;
				end
				spsf_pkg::MODE_SLEEP: begin
					led_d = 1'b0;
				end
				spsf_pkg::MODE_WAITON: begin
					tone = spsf_pkg::TONE_WAITON; led_d = 1'b0;
				end
				spsf_pkg::MODE_ON: begin
					tone = spsf_pkg::TONE_STOP; led_d = 1'b1; load_d = 1'b1;
				end
				spsf_pkg::MODE_WAITOFF: begin
					tone = spsf_pkg::TONE_WAITOFF; led_d = 1'b0;
				end
				default: begin
					load_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= spsf_pkg::MODE_STARTUP;
			ticks_q <= '0;
			led_q   <= 1'b0;
			load_q  <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			ticks_q <= changed ? '0 : ticks_inc;
			led_q   <= led_d;
			load_q  <= load_d;
		end
	end

	assign result.mode         = mode_d;
	assign result.led_on       = led_d;
	assign result.load_on      = load_d;
	assign result.tone_command = tone;
	assign result.mode_changed = changed;

endmodule

FILE: rtl/soft_power_switch_fsm_unit.sv
`timescale 1ns / 1ps
// Top level of the push-button soft power switch controller.
// Depends on spsf_pkg and spsf_fsm.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one beat per system tick,
//    carrying the debounced button event and the tone player's busy flag.
//  - Output channel (out_valid / out_stall / out_data): exactly one beat per
//    input beat, in order: mode, LED and load levels, tone command and a
//    mode-changed flag.
//  - Configuration: cfg_wr_en / cfg_wr_data write the idle timeout in ticks;
//    write it only while no beat is in flight.
//  - Path: a beat accepted into the input register is stepped through the
//    state machine and loaded into the output register once it advances;
//    a stall on the output holds it in the input register until then.
//    The output register holds the result until the receiver takes it.
//  - Throughput: one beat per cycle unless the receiver stalls; the state
//    machine step is a single combinational pass from input to output register.
//  - Reset: mode startup, tick counter zero, LED and load off, timeout 5000,
//    both registers empty.
//  - Receiver stall: the output register holds its beat; the input register
//    still drains into a free output register, and in_stall rises only when
//    both registers are full and the receiver stalls.
module soft_power_switch_fsm_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  spsf_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output spsf_pkg::out_item_t         out_data,
	input  logic                        cfg_wr_en,
	input  logic [spsf_pkg::TICK_W-1:0] cfg_wr_data
);

	logic                        vld_s1;
	spsf_pkg::in_item_t          item_s1;
	logic                        out_vld_q;
	spsf_pkg::out_item_t         out_q;
	logic [spsf_pkg::TICK_W-1:0] timeout_q;
	logic                        advance;
	spsf_pkg::out_item_t         result;

	// Advance the held beat whenever the output register is free or draining.
	assign advance  = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= spsf_pkg::IDLE_TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// Input register: take a new beat or drop to empty when not stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	spsf_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.timeout (timeout_q),
		.result  (result)
	);

	// Output register: load on advance, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

FILE: rtl/spsf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the soft power switch controller, bound to the top.
// Depends on spsf_pkg and soft_power_switch_fsm_unit.
module spsf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input spsf_pkg::out_item_t         out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("accepted beat has no result two edges later");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled output");

	a_tone_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.mode_changed |->
			out_data.tone_command == spsf_pkg::TONE_NONE)
		else $error("tone command without a mode change");

endmodule

bind soft_power_switch_fsm_unit spsf_checker u_spsf_checker (.*);
